@@ hw/rtl/pte_pkg.sv @@
// ----------------------------------------------------------------------------
// pte_pkg
// Shared constants, codes and types of the prefix trie engine.
// ----------------------------------------------------------------------------
package pte_pkg;

   // pool geometry
   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int SLOT_TOTAL    = NODE_COUNT * ALPHABET_SIZE;

   // widths
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int NEXT_W      = $clog2(NODE_COUNT + 1);
   localparam int SLOT_ADDR_W = $clog2(SLOT_TOTAL);
   localparam int FUNC_W      = 2;
   localparam int LETTER_W    = 5;
   localparam int MARK_W      = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // slot marks
   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_PASS  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_END   = 2'd2;

   // one node's marks, one field per letter
   typedef logic [ALPHABET_SIZE-1:0][MARK_W-1:0] mark_row_type;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;  // zero one mark row, advance sweep
      logic lookup;    // transfer accepted: capture letter, issue reads
      logic commit;    // apply the letter to the trie
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;  // sweep at its last row
      logic rsp_busy;    // result register full and not drained this cycle
      logic item_last;   // held letter ends a word
   } status_type;

endpackage

@@ hw/rtl/pte_ctrl.sv @@
// ----------------------------------------------------------------------------
// pte_ctrl
// Sequencer of the trie engine: clearing sweep, letter accept and commit.
// ----------------------------------------------------------------------------
module pte_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pte_pkg::status_type status,
   output pte_pkg::cmd_type    cmd
);

   pte_pkg::state_type state_ff;
   pte_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pte_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pte_pkg::ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = pte_pkg::ST_IDLE;
            end
         end
         pte_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = pte_pkg::ST_COMMIT;
            end
         end
         pte_pkg::ST_COMMIT: begin
            if (!(status.item_last && status.rsp_busy)) begin
               state_in = pte_pkg::ST_IDLE;
            end
         end
         default: state_in = pte_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = 1'b0;
      cmd.clear_wr = 1'b0;
      cmd.lookup   = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         pte_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         pte_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.lookup = req_tvalid;
         end
         pte_pkg::ST_COMMIT: begin
            // a word end waits for a free result register
            cmd.commit = !(status.item_last && status.rsp_busy);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/pte_datapath.sv @@
// ----------------------------------------------------------------------------
// pte_datapath
// Node pool memories, walk cursor, allocation pointer and result register.
// ----------------------------------------------------------------------------
module pte_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pte_pkg::cmd_type                    cmd,
   output pte_pkg::status_type                 status,
   input  logic [pte_pkg::FUNC_W-1:0]          req_func,
   input  logic [pte_pkg::LETTER_W-1:0]        req_letter,
   input  logic                                req_last,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic                                rsp_answer,
   output logic                                rsp_pool_full
);

   localparam logic [pte_pkg::NEXT_W-1:0] NODE_LIMIT =
      pte_pkg::NEXT_W'(pte_pkg::NODE_COUNT);
   localparam logic [pte_pkg::NODE_W-1:0] CLEAR_LAST =
      pte_pkg::NODE_W'(pte_pkg::NODE_COUNT - 1);
   localparam logic [pte_pkg::LETTER_W-1:0] LETTER_LIMIT =
      pte_pkg::LETTER_W'(pte_pkg::ALPHABET_SIZE);

   // pool memories
   pte_pkg::mark_row_type           mark_mem [pte_pkg::NODE_COUNT];
   logic [pte_pkg::NODE_W-1:0]      child_mem [pte_pkg::SLOT_TOTAL];

   // control state
   logic [pte_pkg::NODE_W-1:0]      clr_ff;
   logic [pte_pkg::NODE_W-1:0]      cursor_ff;
   logic [pte_pkg::NEXT_W-1:0]      next_free_ff;
   logic                            path_missing_ff;
   logic                            overflowed_ff;
   logic                            rsp_valid_ff;

   // held letter and read data
   logic [pte_pkg::FUNC_W-1:0]      func_ff;
   logic [pte_pkg::LETTER_W-1:0]    letter_sel_ff;
   logic                            letter_ok_ff;
   logic                            last_ff;
   logic [pte_pkg::SLOT_ADDR_W-1:0] slot_addr_ff;
   pte_pkg::mark_row_type           mark_rd_ff;
   logic [pte_pkg::NODE_W-1:0]      child_rd_ff;
   logic                            answer_ff;
   logic                            pool_full_ff;

   // lookup side
   logic                            letter_ok;
   logic [pte_pkg::LETTER_W-1:0]    letter_sel;
   logic [pte_pkg::SLOT_ADDR_W-1:0] slot_addr;

   // commit side
   logic                            miss_in;
   logic                            ovf_in;
   logic                            hit;
   logic [pte_pkg::NODE_W-1:0]      cursor_in;
   logic [pte_pkg::NEXT_W-1:0]      next_free_in;
   logic                            mark_set;
   logic [pte_pkg::MARK_W-1:0]      new_mark;
   logic                            child_set;
   logic [pte_pkg::MARK_W-1:0]      cur_mark;
   logic                            answer_in;
   pte_pkg::mark_row_type           mark_row_in;

   // mark write port
   logic                            mark_we;
   logic [pte_pkg::NODE_W-1:0]      mark_waddr;
   pte_pkg::mark_row_type           mark_wdata;

   // slot address of the incoming letter, out-of-range letters fold to letter 0
   always_comb begin
      letter_ok  = req_letter < LETTER_LIMIT;
      letter_sel = letter_ok ? req_letter : '0;
      slot_addr  = pte_pkg::SLOT_ADDR_W'(cursor_ff) *
                   pte_pkg::SLOT_ADDR_W'(pte_pkg::ALPHABET_SIZE) +
                   pte_pkg::SLOT_ADDR_W'(letter_sel);
   end

   // capture the accepted letter
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         func_ff       <= req_func;
         letter_sel_ff <= letter_sel;
         letter_ok_ff  <= letter_ok;
         last_ff       <= req_last;
         slot_addr_ff  <= slot_addr;
      end
   end

   // apply one letter to the trie
   always_comb begin
      miss_in      = path_missing_ff | ~letter_ok_ff;
      ovf_in       = overflowed_ff;
      hit          = 1'b0;
      cursor_in    = cursor_ff;
      next_free_in = next_free_ff;
      mark_set     = 1'b0;
      new_mark     = pte_pkg::MARK_EMPTY;
      child_set    = 1'b0;
      cur_mark     = mark_rd_ff[letter_sel_ff];
      if (!miss_in && !ovf_in && func_ff != pte_pkg::FUNC_UNUSED) begin
         if (func_ff == pte_pkg::FUNC_INSERT) begin
            if (cur_mark == pte_pkg::MARK_EMPTY) begin
               if (next_free_ff >= NODE_LIMIT) begin
                  ovf_in = 1'b1;
               end else begin
                  // claim a fresh node
                  mark_set     = 1'b1;
                  new_mark     = last_ff ? pte_pkg::MARK_END : pte_pkg::MARK_PASS;
                  child_set    = 1'b1;
                  cursor_in    = next_free_ff[pte_pkg::NODE_W-1:0];
                  next_free_in = next_free_ff + pte_pkg::NEXT_W'(1);
               end
            end else begin
               if (last_ff) begin
                  mark_set = 1'b1;
                  new_mark = pte_pkg::MARK_END;
               end
               cursor_in = child_rd_ff;
            end
         end else begin
            if (cur_mark == pte_pkg::MARK_EMPTY) begin
               miss_in = 1'b1;
            end else begin
               hit       = (func_ff == pte_pkg::FUNC_PREFIX) ||
                           (cur_mark == pte_pkg::MARK_END);
               cursor_in = child_rd_ff;
            end
         end
      end
      mark_row_in                = mark_rd_ff;
      mark_row_in[letter_sel_ff] = new_mark;
   end

   // answer of a word end
   always_comb begin
      unique case (func_ff)
         pte_pkg::FUNC_INSERT: answer_in = !miss_in && !ovf_in;
         pte_pkg::FUNC_SEARCH,
         pte_pkg::FUNC_PREFIX: answer_in = !miss_in && !ovf_in && hit;
         default:              answer_in = 1'b0;
      endcase
   end

   // mark write port: clearing sweep or commit
   always_comb begin
      mark_we    = cmd.clear_wr || (cmd.commit && mark_set);
      mark_waddr = cmd.clear_wr ? clr_ff : cursor_ff;
      mark_wdata = cmd.clear_wr ? '0 : mark_row_in;
   end

   // mark memory
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (cmd.lookup) begin
         mark_rd_ff <= mark_mem[cursor_ff];
      end
   end

   // child memory
   always_ff @(posedge clock) begin
      if (cmd.commit && child_set) begin
         child_mem[slot_addr_ff] <= next_free_ff[pte_pkg::NODE_W-1:0];
      end
      if (cmd.lookup) begin
         child_rd_ff <= child_mem[slot_addr];
      end
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + pte_pkg::NODE_W'(1);
      end
   end

   // walk state, restarted at the root after each word
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff       <= '0;
         next_free_ff    <= pte_pkg::NEXT_W'(1);
         path_missing_ff <= 1'b0;
         overflowed_ff   <= 1'b0;
      end else if (cmd.commit) begin
         next_free_ff <= next_free_in;
         if (last_ff) begin
            cursor_ff       <= '0;
            path_missing_ff <= 1'b0;
            overflowed_ff   <= 1'b0;
         end else begin
            cursor_ff       <= cursor_in;
            path_missing_ff <= miss_in;
            overflowed_ff   <= ovf_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && last_ff) begin
         answer_ff    <= answer_in;
         pool_full_ff <= ovf_in;
      end
   end

   // status and outputs
   always_comb begin
      status.clear_done = clr_ff == CLEAR_LAST;
      status.rsp_busy   = rsp_valid_ff && !rsp_tready;
      status.item_last  = last_ff;
      rsp_valid         = rsp_valid_ff;
      rsp_answer        = answer_ff;
      rsp_pool_full     = pool_full_ff;
   end

   // the cursor only ever points at an allocated node
   assert property (@(posedge clock) disable iff (reset)
      pte_pkg::NEXT_W'(cursor_ff) < next_free_ff)
      else $error("cursor beyond allocated nodes");

   // allocation never runs past the pool
   assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NODE_LIMIT)
      else $error("allocation pointer past pool end");

   // a word end returns the walk to the root with clear flags
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && last_ff) |=>
         (cursor_ff == '0 && !path_missing_ff && !overflowed_ff && rsp_valid_ff))
      else $error("walk not restarted after word end");

   // an exhausted pool never reports success
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pool_full_ff) |-> !answer_ff)
      else $error("pool full with positive answer");

   // a pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(cmd.commit && last_ff))
      else $error("result register overwritten");

endmodule

@@ hw/rtl/prefix_trie_engine.sv @@
// ----------------------------------------------------------------------------
// prefix_trie_engine
// Lowercase-letter trie in a node pool: insert, exact search, prefix test.
// ----------------------------------------------------------------------------
// Words stream in on the req channel one letter per transfer: the letter in
// req_tdata, the operation in req_tuser, and req_tlast on the final letter.
// Only the final letter of a word yields a transfer on the rsp channel,
// carrying the answer bit and the pool-full flag.
// Each letter has a read step and a commit step: the transfer cycle issues the
// synchronous reads of the cursor node's mark row and of the slot's child
// index, and the commit state applies the letter and writes back. The next
// letter's read address depends on that write-back, so a new letter is not
// taken until the previous one has committed. A result is registered when its
// last letter commits and then shows on rsp_tvalid. If the receiver stalls,
// letters inside a word are still taken; a word's last letter holds in its
// commit step until the result register is free. After reset the mark memory
// is swept clear, one node row per cycle, over all 1024 rows; req_tready stays
// low during the sweep. The pool then holds only the root, where the walk starts.
// ----------------------------------------------------------------------------
module prefix_trie_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pte_pkg::REQ_DATA_W-1:0]     req_tdata,   // [4:0] letter
   input  logic [pte_pkg::FUNC_W-1:0]         req_tuser,   // [1:0] func
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pte_pkg::RSP_DATA_W-1:0]     rsp_tdata    // [0] answer, [1] pool_full
);

   pte_pkg::cmd_type    cmd;
   pte_pkg::status_type status;
   logic                rsp_answer;
   logic                rsp_pool_full;

   // sequencer
   pte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // pool and walk datapath
   pte_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_tuser),
      .req_letter    (req_tdata[pte_pkg::LETTER_W-1:0]),
      .req_last      (req_tlast),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_answer    (rsp_answer),
      .rsp_pool_full (rsp_pool_full)
   );

   // result packing, upper bits zero
   assign rsp_tdata = {{(pte_pkg::RSP_DATA_W - 2){1'b0}}, rsp_pool_full, rsp_answer};

endmodule
